// File: hdl/wtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtd_pkg - shared types and constants
// Angle table for the bearing unit and the vector types it works on.
// ----------------------------------------------------------------------------
package wtd_pkg;

	localparam int ZW = 24;   // angle width, 1/16384 degree
	localparam int VW = 28;   // vector width

	typedef logic signed [ZW-1:0] ang_t;
	typedef logic signed [VW-1:0] vec_t;

	function automatic ang_t atan_lut(input logic [4:0] i);
		case (i)
			5'd0:  atan_lut = 24'sd737280;
			5'd1:  atan_lut = 24'sd435242;
			5'd2:  atan_lut = 24'sd229970;
			5'd3:  atan_lut = 24'sd116736;
			5'd4:  atan_lut = 24'sd58595;
			5'd5:  atan_lut = 24'sd29326;
			5'd6:  atan_lut = 24'sd14667;
			5'd7:  atan_lut = 24'sd7334;
			5'd8:  atan_lut = 24'sd3667;
			5'd9:  atan_lut = 24'sd1833;
			5'd10: atan_lut = 24'sd917;
			5'd11: atan_lut = 24'sd458;
			5'd12: atan_lut = 24'sd229;
			5'd13: atan_lut = 24'sd115;
			5'd14: atan_lut = 24'sd57;
			5'd15: atan_lut = 24'sd29;
			5'd16: atan_lut = 24'sd14;
			5'd17: atan_lut = 24'sd7;
			5'd18: atan_lut = 24'sd4;
			5'd19: atan_lut = 24'sd2;
			5'd20: atan_lut = 24'sd1;
			default: atan_lut = 24'sd0;
		endcase
	endfunction

endpackage

// File: hdl/wtd_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtd_cordic - iterative atan2
// One vectoring step per cycle; result in 1/64 degree, rounded and clamped.
// ----------------------------------------------------------------------------
module wtd_cordic #(
	parameter int ITERS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [24:0]  dx,
	input  logic signed [24:0]  dy,
	output logic                done,
	output logic signed [14:0]  bearing
);
	localparam int CW = $clog2(ITERS + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	wtd_pkg::vec_t x_q, y_q;
	wtd_pkg::ang_t z_q;
	logic          zero_q;
	logic          done_q;
	logic signed [14:0] res_q;

	wtd_pkg::vec_t xs, ys, ex, ey;
	wtd_pkg::ang_t zr;
	logic signed [15:0] rr;

	assign ex = wtd_pkg::VW'(dx);
	assign ey = wtd_pkg::VW'(dy);
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign zr = z_q + wtd_pkg::ZW'(128);
	assign rr = zr[23:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(ITERS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == 0) && (dy == 0);
			if (dx < 0) begin
				if (dy >= 0) begin
					x_q <= ey; y_q <= -ex; z_q <= 24'sd1474560;
				end else begin
					x_q <= -ey; y_q <= ex; z_q <= -24'sd1474560;
				end
			end else begin
				x_q <= ex; y_q <= ey; z_q <= '0;
			end
		end else if (busy_q && cnt_q != CW'(ITERS)) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys; y_q <= y_q - xs;
				z_q <= z_q + wtd_pkg::atan_lut(5'(cnt_q));
			end else begin
				x_q <= x_q - ys; y_q <= y_q + xs;
				z_q <= z_q - wtd_pkg::atan_lut(5'(cnt_q));
			end
		end else if (busy_q) begin
			if (zero_q)              res_q <= '0;
			else if (rr > 16'sd11520)  res_q <= 15'sd11520;
			else if (rr < -16'sd11520) res_q <= -15'sd11520;
			else                     res_q <= rr[14:0];
		end
	end

	assign done    = done_q;
	assign bearing = res_q;
endmodule

// File: hdl/waypoint_turn_then_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_turn_then_drive - turn-then-drive waypoint follower
// Loads waypoints, and on each pose tick emits a speed and turn command.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): a load word writes one waypoint slot and
// gives no output; a tick word carries the pose and yields one output word.
// A tick steps through a table read, CORDIC set-up, one vectoring step per
// cycle in the shared add/shift unit, then a decision step. A load does not
// leave the idle state. in_stall is high while a word is in work and while
// an output word is held unaccepted.
// Output channel (out_valid/out_stall): the word holds until taken; no new
// input word is accepted until then.
// Config channel (cfg_valid/cfg_ready): always ready; write only when idle.
// Reset clears the sequence state and the config and output registers; the
// table is undefined until loaded.
// ----------------------------------------------------------------------------
module waypoint_turn_then_drive #(
	parameter int MAX_WAYPOINTS = 64,
	parameter int CORDIC_ITERS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [23:0] pose_x,
	input  logic signed [23:0] pose_y,
	input  logic signed [14:0] pose_yaw,
	input  logic signed [16:0] passthrough_turn,
	input  logic [5:0]         waypoint_index,
	input  logic signed [23:0] waypoint_x,
	input  logic signed [23:0] waypoint_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        forward_cmd,
	output logic signed [16:0] turn_cmd,
	output logic               target_reached,
	output logic               path_done,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int TW = $clog2(MAX_WAYPOINTS + 2);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_GO   = 3'd2;
	localparam logic [2:0] ST_RUN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [2:0] R_LIN = 3'd0;
	localparam logic [2:0] R_TRN = 3'd1;
	localparam logic [2:0] R_FX  = 3'd2;
	localparam logic [2:0] R_FY  = 3'd3;
	localparam logic [2:0] R_CNT = 3'd4;

	logic [2:0] st_q;
	logic [15:0] lin_q, trn_q;
	logic signed [23:0] fx_q, fy_q;
	logic [6:0] cnt_cfg_q;

	logic [47:0] mem [MAX_WAYPOINTS];
	logic [47:0] rd_q;

	logic [TW-1:0] tidx_q;
	logic signed [23:0] tx_q, ty_q;
	logic signed [16:0] latch_q;
	logic nnew_q, nori_q, first_q, done_q;

	logic signed [23:0] px_q, py_q;
	logic signed [14:0] yaw_q;
	logic signed [16:0] pass_q;
	logic signed [24:0] dx_q, dy_q;

	logic ov_q;
	logic [15:0] fwd_q;
	logic signed [16:0] turn_q;
	logic reach_q, pd_q;

	logic cord_start, cord_done;
	logic signed [14:0] bear;

	wtd_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start),
		.dx(dx_q), .dy(dy_q), .done(cord_done), .bearing(bear)
	);

	assign cord_start = (st_q == ST_GO);

	logic acc;
	assign acc       = in_valid && !in_stall;
	assign in_stall  = (st_q != ST_IDLE) || ov_q;
	assign cfg_ready = 1'b1;

	logic [TW-1:0] cnt_sat;
	assign cnt_sat = (int'(cnt_cfg_q) > MAX_WAYPOINTS) ? TW'(MAX_WAYPOINTS) : TW'(cnt_cfg_q);

	logic signed [16:0] s;
	logic signed [15:0] d, ad;
	logic signed [16:0] tsp;
	assign s   = 17'sd23040 - 17'(yaw_q) + 17'(bear);
	assign d   = 16'(yaw_q) - 16'(bear);
	assign ad  = (d < 0) ? -d : d;
	assign tsp = $signed({1'b0, trn_q});

	logic signed [49:0] d2;
	assign d2 = dx_q * dx_q + dy_q * dy_q;

	always_ff @(posedge clk) begin
		if (acc && action && (MAX_WAYPOINTS >= 64 || waypoint_index < 6'(MAX_WAYPOINTS)))
			mem[AW'(waypoint_index)] <= {waypoint_x, waypoint_y};
		rd_q <= mem[AW'(tidx_q)];
		if (acc) begin
			px_q <= pose_x; py_q <= pose_y; yaw_q <= pose_yaw; pass_q <= passthrough_turn;
		end
		if (st_q == ST_RD) begin
			dx_q <= 25'(tx_q) - 25'(px_q);
			dy_q <= 25'(ty_q) - 25'(py_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			lin_q <= '0; trn_q <= '0; fx_q <= '0; fy_q <= '0; cnt_cfg_q <= '0;
			tidx_q <= '0; tx_q <= '0; ty_q <= '0; latch_q <= '0;
			nnew_q <= 1'b1; nori_q <= 1'b1; first_q <= 1'b1; done_q <= 1'b0;
			ov_q <= 1'b0; fwd_q <= '0; turn_q <= '0; reach_q <= 1'b0; pd_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					R_LIN: lin_q <= cfg_data[15:0];
					R_TRN: trn_q <= cfg_data[15:0];
					R_FX:  fx_q  <= cfg_data;
					R_FY:  fy_q  <= cfg_data;
					R_CNT: cnt_cfg_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (acc && !action) st_q <= ST_RD;
				ST_RD:   st_q <= ST_GO;
				ST_GO:   st_q <= ST_RUN;
				ST_RUN:  if (cord_done) st_q <= ST_OUT;
				ST_OUT: begin
					st_q <= ST_IDLE;
					ov_q <= 1'b1;
					fwd_q <= lin_q; turn_q <= '0; reach_q <= 1'b0; pd_q <= done_q;
					if (nnew_q) begin
						if (tidx_q >= cnt_sat + 1'b1) begin
							done_q <= 1'b1; pd_q <= 1'b1;
						end else begin
							if (tidx_q == cnt_sat) begin
								tx_q <= fx_q; ty_q <= fy_q;
							end else begin
								tx_q <= rd_q[47:24]; ty_q <= rd_q[23:0];
							end
							tidx_q <= tidx_q + 1'b1;
						end
						nnew_q <= 1'b0; nori_q <= 1'b1; turn_q <= pass_q;
					end else if (nori_q) begin
						fwd_q <= '0;
						if (first_q) begin
							if (s >= 0 && ((s >= 17'sd34560 && s < 17'sd46080) ||
									(s >= 17'sd11520 && s < 17'sd23040))) begin
								latch_q <= -tsp; turn_q <= -tsp;
							end else begin
								latch_q <= tsp; turn_q <= tsp;
							end
							first_q <= 1'b0;
						end else if (ad < 16'sd256 || ad > 16'sd22784) begin
							nori_q <= 1'b0;
						end else begin
							turn_q <= latch_q;
						end
					end else begin
						if (d2 < 50'sd65536) begin
							fwd_q <= '0; nnew_q <= 1'b1; reach_q <= 1'b1;
						end
						first_q <= 1'b1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = ov_q;
	assign forward_cmd    = fwd_q;
	assign turn_cmd       = turn_q;
	assign target_reached = reach_q;
	assign path_done      = pd_q;
endmodule
